>>> src/csvs_pkg.sv
// Shared types, constants and helpers of the CSV line field splitter.
`default_nettype none

package csvs_pkg;

    localparam int PENDING_DEPTH = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_DELIMITER = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_QUOTE     = 1'b1;

    localparam logic [7:0] DELIMITER_RESET = 8'd44;
    localparam logic [7:0] QUOTE_RESET     = 8'd34;

    typedef enum logic [2:0] {
        PM_START,
        PM_LEAD,
        PM_CONTENT,
        PM_QUOTED,
        PM_QSEEN
    } parse_mode_t;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_EMIT,
        CMD_FLUSH_EMIT,
        CMD_QUOTE_EMIT
    } cmd_kind_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_FLUSH_OUT,
        BK_OVF_OUT,
        BK_QUOTE_OUT,
        BK_FINAL_OUT
    } back_state_t;

    // One command from the front to the back.
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] value;
        logic       has_byte;
        logic       field_end;
        logic       line_end;
        logic [7:0] aux;
    } cmd_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       field_end;
        logic       line_end;
        logic       trim_overflow;
        logic       run_last;
    } out_item_t;

    // Space, TAB, LF, VT, FF and CR.
    function automatic logic is_space(input logic [7:0] b);
        is_space = (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

endpackage

`default_nettype wire

>>> src/csvs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module csvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> src/csvs_front.sv
// Front end: configuration registers, byte acceptance and field parsing into commands.
`default_nettype none

module csvs_front (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [csvs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                       cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [7:0]                       s_in_byte,
    input  wire logic                             s_line_last,
    input  wire logic                             q_full,
    output logic                                  q_push,
    output csvs_pkg::cmd_t                        q_cmd
);

    logic [7:0]            delimiter_reg;
    logic [7:0]            quote_reg;
    csvs_pkg::parse_mode_t mode_reg;
    csvs_pkg::parse_mode_t mode_next;
    logic                  accept;
    logic                  is_delim;
    logic                  is_quote;
    logic                  is_ws;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full;
    assign accept    = s_valid && s_ready;
    assign is_delim  = (s_in_byte == delimiter_reg);
    assign is_quote  = (s_in_byte == quote_reg);
    assign is_ws     = csvs_pkg::is_space(s_in_byte);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delimiter_reg <= csvs_pkg::DELIMITER_RESET;
            quote_reg     <= csvs_pkg::QUOTE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                csvs_pkg::REG_DELIMITER: delimiter_reg <= cfg_data;
                csvs_pkg::REG_QUOTE:     quote_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= csvs_pkg::PM_START;
        end else begin
            mode_reg <= mode_next;
        end
    end

    always_comb begin
        mode_next          = mode_reg;
        q_push             = 1'b0;
        q_cmd.kind         = csvs_pkg::CMD_EMIT;
        q_cmd.value        = 8'd0;
        q_cmd.has_byte     = 1'b0;
        q_cmd.field_end    = 1'b1;
        q_cmd.line_end     = s_line_last;
        q_cmd.aux          = quote_reg;
        if (accept) begin
            case (mode_reg)
                csvs_pkg::PM_LEAD, csvs_pkg::PM_CONTENT: begin
                    if (is_delim) begin
                        q_push    = 1'b1;
                        mode_next = csvs_pkg::PM_START;
                    end else if (is_ws) begin
                        if (s_line_last) begin
                            q_push = 1'b1;
                        end else if (mode_reg == csvs_pkg::PM_CONTENT) begin
                            // Possible trailing whitespace: park it in the pending store.
                            q_push      = 1'b1;
                            q_cmd.kind  = csvs_pkg::CMD_PUSH;
                            q_cmd.value = s_in_byte;
                        end
                    end else begin
                        q_push          = 1'b1;
                        q_cmd.kind      = csvs_pkg::CMD_FLUSH_EMIT;
                        q_cmd.value     = s_in_byte;
                        q_cmd.has_byte  = 1'b1;
                        q_cmd.field_end = s_line_last;
                        mode_next       = csvs_pkg::PM_CONTENT;
                    end
                end
                csvs_pkg::PM_QUOTED: begin
                    if (is_quote) begin
                        if (s_line_last) begin
                            q_push = 1'b1;
                        end else begin
                            mode_next = csvs_pkg::PM_QSEEN;
                        end
                    end else begin
                        q_push          = 1'b1;
                        q_cmd.value     = s_in_byte;
                        q_cmd.has_byte  = 1'b1;
                        q_cmd.field_end = s_line_last;
                    end
                end
                csvs_pkg::PM_QSEEN: begin
                    q_push = 1'b1;
                    if (is_delim) begin
                        mode_next = csvs_pkg::PM_START;
                    end else if (is_quote) begin
                        q_cmd.value     = quote_reg;
                        q_cmd.has_byte  = 1'b1;
                        q_cmd.field_end = s_line_last;
                        mode_next       = csvs_pkg::PM_QUOTED;
                    end else begin
                        // The lone quote is kept ahead of this byte.
                        q_cmd.kind      = csvs_pkg::CMD_QUOTE_EMIT;
                        q_cmd.value     = s_in_byte;
                        q_cmd.has_byte  = 1'b1;
                        q_cmd.field_end = s_line_last;
                        mode_next       = csvs_pkg::PM_QUOTED;
                    end
                end
                default: begin
                    if (is_quote) begin
                        if (s_line_last) begin
                            q_push = 1'b1;
                        end else begin
                            mode_next = csvs_pkg::PM_QUOTED;
                        end
                    end else if (is_delim) begin
                        q_push    = 1'b1;
                        mode_next = csvs_pkg::PM_START;
                    end else if (is_ws) begin
                        if (s_line_last) begin
                            q_push = 1'b1;
                        end else begin
                            mode_next = csvs_pkg::PM_LEAD;
                        end
                    end else begin
                        q_push          = 1'b1;
                        q_cmd.value     = s_in_byte;
                        q_cmd.has_byte  = 1'b1;
                        q_cmd.field_end = s_line_last;
                        mode_next       = csvs_pkg::PM_CONTENT;
                    end
                end
            endcase
            if (s_line_last) begin
                mode_next = csvs_pkg::PM_START;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/csvs_cmd_queue.sv
// Short command queue between the front and the back.
`default_nettype none

module csvs_cmd_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire csvs_pkg::cmd_t push_cmd,
    output logic                full,
    input  wire logic           pop,
    output csvs_pkg::cmd_t      head_cmd,
    output logic                empty
);

    csvs_pkg::cmd_t                  entry_reg [csvs_pkg::QUEUE_DEPTH];
    logic [csvs_pkg::QUEUE_AW-1:0]   wr_ptr_reg;
    logic [csvs_pkg::QUEUE_AW-1:0]   rd_ptr_reg;
    logic [csvs_pkg::QUEUE_CW-1:0]   count_reg;

    assign full     = (count_reg == csvs_pkg::QUEUE_CW'(csvs_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("command queue written while full");

    a_no_pop_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("command queue read while empty");
`endif

endmodule

`default_nettype wire

>>> src/csvs_back.sv
// Back end: pending whitespace store, command execution and the output register.
`default_nettype none

module csvs_back #(
    parameter int PENDING_DEPTH = csvs_pkg::PENDING_DEPTH
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           q_empty,
    input  wire csvs_pkg::cmd_t q_cmd,
    output logic                q_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_has_byte,
    output logic                m_field_end,
    output logic                m_line_end,
    output logic                m_trim_overflow,
    output logic                m_run_last
);

    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW = $clog2(PENDING_DEPTH + 1);
    localparam int SW = CW + 1;

    csvs_pkg::back_state_t state_reg;
    csvs_pkg::back_state_t state_next;
    csvs_pkg::cmd_t        cmd_reg;
    csvs_pkg::cmd_t        cmd_next;
    logic [AW-1:0]         head_reg;
    logic [AW-1:0]         head_next;
    logic [CW-1:0]         count_reg;
    logic [CW-1:0]         count_next;
    logic                  m_valid_reg;
    csvs_pkg::out_item_t   out_reg;
    csvs_pkg::out_item_t   out_next;
    logic                  out_load;
    logic                  out_free;
    logic [AW-1:0]         head_inc;
    logic [SW-1:0]         tail_sum;
    logic [SW-1:0]         tail_wrap;
    logic [AW-1:0]         tail_addr;
    logic                  store_full;
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [7:0]            ram_wdata;
    logic [7:0]            ram_rdata;

    assign out_free   = !m_valid_reg || m_ready;
    assign store_full = (count_reg == CW'(PENDING_DEPTH));
    assign head_inc   = (head_reg == AW'(PENDING_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_sum   = SW'(head_reg) + SW'(count_reg);
    assign tail_wrap  = (tail_sum >= SW'(PENDING_DEPTH)) ? tail_sum - SW'(PENDING_DEPTH)
                                                          : tail_sum;
    assign tail_addr  = tail_wrap[AW-1:0];

    // The store is a ring: entries run from head for count bytes.
    csvs_ram #(
        .WIDTH (8),
        .DEPTH (PENDING_DEPTH),
        .AW    (AW)
    ) u_pending (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= csvs_pkg::BK_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    always_comb begin
        state_next             = state_reg;
        cmd_next               = cmd_reg;
        head_next              = head_reg;
        count_next             = count_reg;
        q_pop                  = 1'b0;
        out_load               = 1'b0;
        out_next.out_byte      = cmd_reg.value;
        out_next.has_byte      = cmd_reg.has_byte;
        out_next.field_end     = cmd_reg.field_end;
        out_next.line_end      = cmd_reg.line_end;
        out_next.trim_overflow = 1'b0;
        out_next.run_last      = 1'b1;
        ram_we                 = 1'b0;
        ram_waddr              = tail_addr;
        ram_wdata              = q_cmd.value;
        case (state_reg)
            csvs_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    q_pop    = 1'b1;
                    cmd_next = q_cmd;
                    case (q_cmd.kind)
                        csvs_pkg::CMD_PUSH: begin
                            if (store_full) begin
                                state_next = csvs_pkg::BK_READ;
                            end else begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        csvs_pkg::CMD_FLUSH_EMIT: begin
                            if (count_reg == '0) begin
                                state_next = csvs_pkg::BK_FINAL_OUT;
                            end else begin
                                state_next = csvs_pkg::BK_READ;
                            end
                        end
                        csvs_pkg::CMD_QUOTE_EMIT: begin
                            state_next = csvs_pkg::BK_QUOTE_OUT;
                        end
                        default: begin
                            // Delimiters and line ends drop whatever is pending.
                            head_next  = '0;
                            count_next = '0;
                            state_next = csvs_pkg::BK_FINAL_OUT;
                        end
                    endcase
                end
            end
            csvs_pkg::BK_READ: begin
                // The read of the head entry settles during this cycle.
                if (cmd_reg.kind == csvs_pkg::CMD_PUSH) begin
                    state_next = csvs_pkg::BK_OVF_OUT;
                end else begin
                    state_next = csvs_pkg::BK_FLUSH_OUT;
                end
            end
            csvs_pkg::BK_FLUSH_OUT: begin
                out_next.out_byte  = ram_rdata;
                out_next.has_byte  = 1'b1;
                out_next.field_end = 1'b0;
                out_next.line_end  = 1'b0;
                out_next.run_last  = 1'b0;
                if (out_free) begin
                    out_load   = 1'b1;
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                    if (count_reg == CW'(1)) begin
                        state_next = csvs_pkg::BK_FINAL_OUT;
                    end else begin
                        state_next = csvs_pkg::BK_READ;
                    end
                end
            end
            csvs_pkg::BK_OVF_OUT: begin
                out_next.out_byte      = ram_rdata;
                out_next.has_byte      = 1'b1;
                out_next.field_end     = 1'b0;
                out_next.line_end      = 1'b0;
                out_next.trim_overflow = 1'b1;
                // With the ring full, the tail slot is the one just read out.
                ram_waddr = head_reg;
                ram_wdata = cmd_reg.value;
                if (out_free) begin
                    out_load   = 1'b1;
                    ram_we     = 1'b1;
                    head_next  = head_inc;
                    state_next = csvs_pkg::BK_IDLE;
                end
            end
            csvs_pkg::BK_QUOTE_OUT: begin
                out_next.out_byte  = cmd_reg.aux;
                out_next.has_byte  = 1'b1;
                out_next.field_end = 1'b0;
                out_next.line_end  = 1'b0;
                out_next.run_last  = 1'b0;
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = csvs_pkg::BK_FINAL_OUT;
                end
            end
            csvs_pkg::BK_FINAL_OUT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = csvs_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = csvs_pkg::BK_IDLE;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = out_reg.out_byte;
    assign m_has_byte      = out_reg.has_byte;
    assign m_field_end     = out_reg.field_end;
    assign m_line_end      = out_reg.line_end;
    assign m_trim_overflow = out_reg.trim_overflow;
    assign m_run_last      = out_reg.run_last;

`ifndef ASSERT_OFF
    a_count_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(PENDING_DEPTH))
        else $error("pending count beyond store depth");

    a_flush_has_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == csvs_pkg::BK_FLUSH_OUT) |-> (count_reg != '0))
        else $error("flush step with an empty pending store");

    a_overflow_word_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_next.trim_overflow) |-> (out_next.has_byte && out_next.run_last
            && !out_next.field_end && store_full))
        else $error("overflow word without a full store or with bad marks");
`endif

endmodule

`default_nettype wire

>>> src/csv_line_field_splitter_core.sv
// Top level of the CSV line field splitter: front parser, command queue and back end.
// A byte that yields one word passes the command queue and the back end's command and
// output registers before showing on m_valid. The back end emits a plain word from
// final-output, a pending byte via read and flush-output, an overflow via read
// and overflow-output. The queue lets the front accept bytes as the back end drains.
// Synchronous active-low reset clears the parse mode, queue, pending count and
// output valid, and restores the delimiter to comma and the quote to double quote.
`default_nettype none

module csv_line_field_splitter_core #(
    parameter int PENDING_DEPTH = csvs_pkg::PENDING_DEPTH
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [csvs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                       cfg_data,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [7:0]                       s_in_byte,
    input  wire logic                             s_line_last,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [7:0]                            m_out_byte,
    output logic                                  m_has_byte,
    output logic                                  m_field_end,
    output logic                                  m_line_end,
    output logic                                  m_trim_overflow,
    output logic                                  m_run_last
);

    logic           q_full;
    logic           q_empty;
    logic           q_push;
    logic           q_pop;
    csvs_pkg::cmd_t push_cmd;
    csvs_pkg::cmd_t head_cmd;

    csvs_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_line_last (s_line_last),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    csvs_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    csvs_back #(
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_empty         (q_empty),
        .q_cmd           (head_cmd),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_has_byte      (m_has_byte),
        .m_field_end     (m_field_end),
        .m_line_end      (m_line_end),
        .m_trim_overflow (m_trim_overflow),
        .m_run_last      (m_run_last)
    );

endmodule

`default_nettype wire

>>> sim/csv_line_field_splitter_core_tb.sv
// Self-checking testbench for the CSV line field splitter core.
module csv_line_field_splitter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_BYTES  = 12;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } line_byte_t;

    typedef logic [7:0] byte_list_t[$];

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_style_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [csvs_pkg::CFG_INDEX_W-1:0] cfg_index = csvs_pkg::REG_DELIMITER;
    logic [7:0]                       cfg_data = 8'h00;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [7:0]                       s_in_byte = 8'h00;
    logic                             s_line_last = 1'b0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [7:0]                       m_out_byte;
    logic                             m_has_byte;
    logic                             m_field_end;
    logic                             m_line_end;
    logic                             m_trim_overflow;
    logic                             m_run_last;

    // Predictor state, kept in step with the configuration written to the block.
    csvs_pkg::parse_mode_t pmode = csvs_pkg::PM_START;
    logic [7:0]            spaces[csvs_pkg::PENDING_DEPTH];
    int                    space_cnt = 0;
    logic [7:0]            delim = csvs_pkg::DELIMITER_RESET;
    logic [7:0]            quot = csvs_pkg::QUOTE_RESET;

    line_byte_t            byte_feed[$];
    csvs_pkg::out_item_t   expected_words[$];
    int                    mismatches = 0;

    line_byte_t            next_item;
    int                    burst_left = 1;
    int                    gap_left = 0;

    logic                  hold_req = 1'b0;
    logic                  hold_taken = 1'b0;
    int                    hold_left = 0;
    rx_style_t             rx_style = RX_OPEN;
    int                    rx_left = 0;
    logic [7:0]            rx_pat = 8'b1011_0010;

    csvs_pkg::out_item_t   got;
    csvs_pkg::out_item_t   want;
    int                    stall_cycles = 0;

    csv_line_field_splitter_core #(
        .PENDING_DEPTH(csvs_pkg::PENDING_DEPTH)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_in_byte(s_in_byte),
        .s_line_last(s_line_last),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_byte(m_out_byte),
        .m_has_byte(m_has_byte),
        .m_field_end(m_field_end),
        .m_line_end(m_line_end),
        .m_trim_overflow(m_trim_overflow),
        .m_run_last(m_run_last)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic csvs_pkg::out_item_t make_word(input logic [7:0] b, input logic has,
                                                      input logic fe, input logic le,
                                                      input logic ovf);
        csvs_pkg::out_item_t w;
        w.out_byte      = has ? b : 8'h00;
        w.has_byte      = has;
        w.field_end     = fe;
        w.line_end      = le;
        w.trim_overflow = ovf;
        w.run_last      = 1'b0;
        return w;
    endfunction

    // Works out the words that one accepted byte must produce and queues them.
    function automatic void split_byte(input logic [7:0] b, input logic last);
        csvs_pkg::out_item_t run[$];
        case (pmode)
            csvs_pkg::PM_LEAD, csvs_pkg::PM_CONTENT: begin
                if (b == delim) begin
                    space_cnt = 0;
                    run.push_back(make_word(8'h00, 1'b0, 1'b1, last, 1'b0));
                    pmode = csvs_pkg::PM_START;
                end else if (is_blank(b)) begin
                    if (last) begin
                        space_cnt = 0;
                        run.push_back(make_word(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
                    end else if (pmode == csvs_pkg::PM_CONTENT) begin
                        // A full store gives up its oldest byte to make room.
                        if (space_cnt >= csvs_pkg::PENDING_DEPTH) begin
                            run.push_back(make_word(spaces[0], 1'b1, 1'b0, 1'b0, 1'b1));
                            for (int i = 1; i < csvs_pkg::PENDING_DEPTH; i++)
                                spaces[i-1] = spaces[i];
                            space_cnt = csvs_pkg::PENDING_DEPTH - 1;
                        end
                        spaces[space_cnt] = b;
                        space_cnt++;
                    end
                end else begin
                    for (int i = 0; i < space_cnt; i++)
                        run.push_back(make_word(spaces[i], 1'b1, 1'b0, 1'b0, 1'b0));
                    space_cnt = 0;
                    run.push_back(make_word(b, 1'b1, last, last, 1'b0));
                    pmode = csvs_pkg::PM_CONTENT;
                end
            end
            csvs_pkg::PM_QUOTED: begin
                if (b == quot) begin
                    if (last)
                        run.push_back(make_word(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
                    else
                        pmode = csvs_pkg::PM_QSEEN;
                end else begin
                    run.push_back(make_word(b, 1'b1, last, last, 1'b0));
                end
            end
            csvs_pkg::PM_QSEEN: begin
                if (b == delim) begin
                    run.push_back(make_word(8'h00, 1'b0, 1'b1, last, 1'b0));
                    pmode = csvs_pkg::PM_START;
                end else if (b == quot) begin
                    run.push_back(make_word(quot, 1'b1, last, last, 1'b0));
                    pmode = csvs_pkg::PM_QUOTED;
                end else begin
                    run.push_back(make_word(quot, 1'b1, 1'b0, 1'b0, 1'b0));
                    run.push_back(make_word(b, 1'b1, last, last, 1'b0));
                    pmode = csvs_pkg::PM_QUOTED;
                end
            end
            default: begin
                space_cnt = 0;
                if (b == quot) begin
                    if (last)
                        run.push_back(make_word(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
                    else
                        pmode = csvs_pkg::PM_QUOTED;
                end else if (b == delim) begin
                    run.push_back(make_word(8'h00, 1'b0, 1'b1, last, 1'b0));
                    pmode = csvs_pkg::PM_START;
                end else if (is_blank(b)) begin
                    if (last)
                        run.push_back(make_word(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));
                    else
                        pmode = csvs_pkg::PM_LEAD;
                end else begin
                    run.push_back(make_word(b, 1'b1, last, last, 1'b0));
                    pmode = csvs_pkg::PM_CONTENT;
                end
            end
        endcase
        if (last) begin
            pmode = csvs_pkg::PM_START;
            space_cnt = 0;
        end
        if (run.size() != 0)
            run[run.size()-1].run_last = 1'b1;
        foreach (run[i])
            expected_words.push_back(run[i]);
    endfunction

    function automatic string word_text(input csvs_pkg::out_item_t w);
        return $sformatf("byte=%02h has=%b fe=%b le=%b ovf=%b last=%b", w.out_byte,
                         w.has_byte, w.field_end, w.line_end, w.trim_overflow, w.run_last);
    endfunction

    function automatic void note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s", $time, msg);
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                split_byte(s_in_byte, s_line_last);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_valid <= 1'b0;
                end else if (byte_feed.size() != 0) begin
                    next_item = byte_feed.pop_front();
                    s_in_byte <= next_item.value;
                    s_line_last <= next_item.last;
                    s_valid <= 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: switches between stall styles, with one long hold-off on request.
    always @(posedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= LONG_HOLD;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_style <= rx_style_t'($urandom_range(0, 3));
                rx_left <= $urandom_range(8, 60);
            end else begin
                rx_left <= rx_left - 1;
            end
            rx_pat <= {rx_pat[0], rx_pat[7:1]};
            case (rx_style)
                RX_OPEN:    m_ready <= 1'b1;
                RX_COIN:    m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE:  m_ready <= ($urandom_range(0, 3) == 0);
                default:    m_ready <= rx_pat[0];
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got.out_byte      = m_out_byte;
            got.has_byte      = m_has_byte;
            got.field_end     = m_field_end;
            got.line_end      = m_line_end;
            got.trim_overflow = m_trim_overflow;
            got.run_last      = m_run_last;
            if (expected_words.size() == 0) begin
                note_mismatch({"unexpected word: ", word_text(got)});
            end else begin
                want = expected_words.pop_front();
                if (got !== want)
                    note_mismatch({"expected ", word_text(want), ", got ", word_text(got)});
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic feed_line(input byte_list_t bytes);
        line_byte_t lb;
        foreach (bytes[i]) begin
            lb.value = bytes[i];
            lb.last  = (i == bytes.size() - 1);
            byte_feed.push_back(lb);
        end
    endtask

    task automatic feed_text(input string s);
        byte_list_t bytes;
        for (int i = 0; i < s.len(); i++)
            bytes.push_back(s[i]);
        feed_line(bytes);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == delim || b == quot);
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        logic [7:0] b;
        do
            b = ($urandom_range(0, 5) == 0) ? 8'h20 : 8'($urandom_range(9, 13));
        while (b == delim || b == quot);
        return b;
    endfunction

    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 4))
            0:       return delim;
            1:       return quot;
            2:       return blank_byte();
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed lines with random fields; now and then a short burst of noise.
    task automatic build_line(inout int count);
        byte_list_t bytes;
        int nfields;
        int kind;
        if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 8)) bytes.push_back(noise_byte());
        end else begin
            nfields = $urandom_range(1, 4);
            for (int f = 0; f < nfields; f++) begin
                if (f > 0)
                    bytes.push_back(delim);
                kind = $urandom_range(0, 9);
                if (kind < 4) begin
                    repeat ($urandom_range(0, 2)) bytes.push_back(blank_byte());
                    bytes.push_back(plain_byte());
                    if ($urandom_range(0, 5) == 0)
                        bytes.push_back(quot);
                    repeat ($urandom_range(0, 3)) bytes.push_back(plain_byte());
                    if ($urandom_range(0, 2) == 0) begin
                        bytes.push_back(blank_byte());
                        bytes.push_back(plain_byte());
                    end
                    // Long trailing runs can push the pending store past its depth.
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(14, 20)) bytes.push_back(blank_byte());
                    else
                        repeat ($urandom_range(0, 3)) bytes.push_back(blank_byte());
                end else if (kind < 8) begin
                    bytes.push_back(quot);
                    repeat ($urandom_range(0, 5)) begin
                        case ($urandom_range(0, 5))
                            0: bytes.push_back(delim);
                            1: begin
                                bytes.push_back(quot);
                                bytes.push_back(quot);
                            end
                            2: begin
                                bytes.push_back(quot);
                                bytes.push_back(plain_byte());
                            end
                            default: bytes.push_back(plain_byte());
                        endcase
                    end
                    if (f != nfields - 1 || $urandom_range(0, 3) != 0)
                        bytes.push_back(quot);
                end else if (kind == 8) begin
                    repeat ($urandom_range(1, 3)) bytes.push_back(blank_byte());
                end
            end
            if ($urandom_range(0, 4) == 0)
                bytes.push_back(delim);
            if (bytes.size() == 0)
                bytes.push_back(plain_byte());
        end
        feed_line(bytes);
        count += bytes.size();
    endtask

    // Returns once every byte is taken and every word has come, plus a margin
    // for bytes that only fill the pending store.
    task automatic wait_idle();
        do
            @(negedge aclk);
        while (byte_feed.size() != 0 || s_valid || expected_words.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [7:0] d, input logic [7:0] q);
        @(posedge aclk);
        cfg_index <= csvs_pkg::REG_DELIMITER;
        cfg_data <= d;
        cfg_valid <= 1'b1;
        do
            @(posedge aclk);
        while (!cfg_ready);
        delim = d;
        cfg_index <= csvs_pkg::REG_QUOTE;
        cfg_data <= q;
        do
            @(posedge aclk);
        while (!cfg_ready);
        quot = q;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [7:0] delim_set[6] = '{8'h3B, 8'h00, 8'hFF, 8'h22, 8'h09, 8'h2C};
        logic [7:0] quote_set[6] = '{8'h27, 8'hFF, 8'h00, 8'h22, 8'h22, 8'h22};
        int phase_bytes;
        byte_list_t zero_ff;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        feed_text("a,b");
        feed_text("x,");
        feed_text(" ,q");
        feed_text(" \"z");
        feed_text("\"");
        feed_text("\"a,\"\"\"b\",");
        feed_text("\"c");
        feed_text("\"d\"");
        zero_ff.push_back(8'h00);
        zero_ff.push_back(8'hFF);
        feed_line(zero_ff);
        feed_text("k \t");

        for (int p = 0; p < 6; p++) begin
            wait_idle();
            set_config(delim_set[p], quote_set[p]);
            @(negedge aclk);
            // The first random phase runs against a long receiver hold-off.
            if (p == 0)
                hold_req = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
                build_line(phase_bytes);
        end

        wait_idle();
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
